FILE: rtl/rle_pattern_run_decoder_top_macros.svh
// assertion macros for the run-length pattern decoder
// used by the port checker; needs nothing else
`ifndef RLE_PATTERN_RUN_DECODER_TOP_MACROS_SVH
`define RLE_PATTERN_RUN_DECODER_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define RLEPD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off during reset
`define RLEPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/rlepd_pkg.sv
// shared types and constants of the run-length pattern decoder
// no dependencies
`default_nettype none

package rlepd_pkg;

   // grid size limits used as parameter defaults
   localparam int DEF_MAX_ROWS = 1024;
   localparam int DEF_MAX_COLS = 1024;

   // configuration register and port widths
   localparam int CFG_W     = 11;
   localparam int CSR_IDX_W = 2;

   // result field widths
   localparam int START_W = 20;
   localparam int LEN_W   = 21;

   // smallest grid side and margin used by the too-large pattern test
   localparam int MIN_DIM    = 2;
   localparam int DIM_MARGIN = 2;

   // pattern characters
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;
   localparam logic [7:0] CHAR_RUN_LIVE = 8'h6F;
   localparam logic [7:0] CHAR_RUN_DEAD = 8'h62;
   localparam logic [7:0] CHAR_ROW_END  = 8'h24;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_ROWS      = 2'd0,
      CSR_GRID_COLS      = 2'd1,
      CSR_PATTERN_WIDTH  = 2'd2,
      CSR_PATTERN_HEIGHT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] grid_rows;
      logic [CFG_W-1:0] grid_cols;
      logic [CFG_W-1:0] pattern_width;
      logic [CFG_W-1:0] pattern_height;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      grid_rows:      11'd64,
      grid_cols:      11'd64,
      pattern_width:  11'd0,
      pattern_height: 11'd0
   };

   // one result word
   typedef struct packed {
      logic               run_valid;
      logic [START_W-1:0] run_start;
      logic [LEN_W-1:0]   run_length;
      logic               too_large;
      logic               clipped;
   } rsp_word_type;

endpackage

`default_nettype wire

FILE: rtl/rlepd_req_if.sv
// input channel: one pattern character per word
// depends on nothing
`default_nettype none

interface rlepd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_char;
   logic       first_char;

   modport source (output valid, output code_char, output first_char, input ready);
   modport sink   (input valid, input code_char, input first_char, output ready);
endinterface

`default_nettype wire

FILE: rtl/rlepd_rsp_if.sv
// result channel: one fill run word per pattern character
// depends on rlepd_pkg
`default_nettype none

interface rlepd_rsp_if;
   import rlepd_pkg::*;

   logic               valid;
   logic               ready;
   logic               run_valid;
   logic [START_W-1:0] run_start;
   logic [LEN_W-1:0]   run_length;
   logic               too_large;
   logic               clipped;

   modport source (output valid, output run_valid, output run_start, output run_length,
                   output too_large, output clipped, input ready);
   modport sink   (input valid, input run_valid, input run_start, input run_length,
                   input too_large, input clipped, output ready);
endinterface

`default_nettype wire

FILE: rtl/rle_pattern_run_decoder_top.sv
// run-length pattern decoder: one character in, one fill run word out
// a result word is registered in the output register, or in the skid register, before it shows on rsp
// throughput: one character per cycle while the buffer has room, set by the row multiplier
// a two-word result buffer keeps input flowing while one result waits
// reset (synchronous, active high) clears decode state and restores register defaults
// depends on rlepd_pkg, rlepd_req_if, rlepd_rsp_if, rlepd_core, rlepd_out_buf
`default_nettype none

module rle_pattern_run_decoder_top #(
   parameter int MAX_ROWS = rlepd_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = rlepd_pkg::DEF_MAX_COLS
) (
   input  logic                           clock,
   input  logic                           reset,
   rlepd_req_if.sink                      req_bus,
   rlepd_rsp_if.source                    rsp_bus,
   input  logic                           csr_wr_en,
   input  logic [rlepd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rlepd_pkg::CFG_W-1:0]     csr_wdata
);
   import rlepd_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   rsp_word_type core_word, out_word;
   logic         buf_in_ready, item_accept;

   // register write decode; reset value is seen by the geometry at once
   always_comb begin
      cfg_in = cfg_ff;
      if (reset) begin
         cfg_in = CFG_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_GRID_ROWS:      cfg_in.grid_rows      = csr_wdata;
            CSR_GRID_COLS:      cfg_in.grid_cols      = csr_wdata;
            CSR_PATTERN_WIDTH:  cfg_in.pattern_width  = csr_wdata;
            CSR_PATTERN_HEIGHT: cfg_in.pattern_height = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input handshake
   assign req_bus.ready = buf_in_ready;
   assign item_accept   = req_bus.valid && buf_in_ready;

   rlepd_core #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg_next    (cfg_in),
      .item_accept (item_accept),
      .code_char   (req_bus.code_char),
      .first_char  (req_bus.first_char),
      .result      (core_word)
   );

   rlepd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (buf_in_ready),
      .in_word   (core_word),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_word  (out_word)
   );

   // result fields onto the channel
   assign rsp_bus.run_valid  = out_word.run_valid;
   assign rsp_bus.run_start  = out_word.run_start;
   assign rsp_bus.run_length = out_word.run_length;
   assign rsp_bus.too_large  = out_word.too_large;
   assign rsp_bus.clipped    = out_word.clipped;

endmodule

`default_nettype wire

FILE: rtl/rlepd_core.sv
// decode state and per-character datapath: grid geometry, repeat count, position
// depends on rlepd_pkg
`default_nettype none

module rlepd_core #(
   parameter int MAX_ROWS = rlepd_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = rlepd_pkg::DEF_MAX_COLS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rlepd_pkg::cfg_type      cfg_next,
   input  logic                    item_accept,
   input  logic [7:0]              code_char,
   input  logic                    first_char,
   output rlepd_pkg::rsp_word_type result
);
   import rlepd_pkg::*;

   localparam int ROW_W   = $clog2(MAX_ROWS + 1);
   localparam int COL_W   = $clog2(MAX_COLS + 1);
   localparam int TOTAL_W = $clog2(MAX_ROWS * MAX_COLS + 1);
   localparam int PROD_W  = ROW_W + COL_W;
   localparam int MUL_W   = TOTAL_W + 4;
   localparam int DIM_A   = (ROW_W > COL_W) ? ROW_W : COL_W;
   localparam int DIM_W   = (DIM_A > CFG_W + 1) ? DIM_A : CFG_W + 1;

   // geometry from the configuration as it stands after this edge
   logic [DIM_W-1:0]  rows_x, cols_x, pw_x, ph_x, srow_x, col0_x;
   logic              big_x;
   logic [ROW_W-1:0]  rows_g, srow_g;
   logic [COL_W-1:0]  cols_g, col0_g;
   logic [PROD_W-1:0] total_prod, spos_prod;

   logic [ROW_W-1:0]   rows_ff, srow_ff;
   logic [COL_W-1:0]   cols_ff, col0_ff;
   logic [TOTAL_W-1:0] total_ff, spos_ff;
   logic               big_ff;

   always_comb begin
      pw_x = DIM_W'(cfg_next.pattern_width);
      ph_x = DIM_W'(cfg_next.pattern_height);

      // clamp grid sides into the supported range
      if (DIM_W'(cfg_next.grid_rows) < DIM_W'(MIN_DIM)) begin
         rows_x = DIM_W'(MIN_DIM);
      end else if (DIM_W'(cfg_next.grid_rows) > DIM_W'(MAX_ROWS)) begin
         rows_x = DIM_W'(MAX_ROWS);
      end else begin
         rows_x = DIM_W'(cfg_next.grid_rows);
      end
      if (DIM_W'(cfg_next.grid_cols) < DIM_W'(MIN_DIM)) begin
         cols_x = DIM_W'(MIN_DIM);
      end else if (DIM_W'(cfg_next.grid_cols) > DIM_W'(MAX_COLS)) begin
         cols_x = DIM_W'(MAX_COLS);
      end else begin
         cols_x = DIM_W'(cfg_next.grid_cols);
      end

      big_x  = (pw_x + DIM_W'(DIM_MARGIN) > cols_x) || (ph_x + DIM_W'(DIM_MARGIN) > rows_x);
      srow_x = (rows_x >> 1) - (ph_x >> 1);
      col0_x = (cols_x >> 1) - (pw_x >> 1);

      rows_g = ROW_W'(rows_x);
      cols_g = COL_W'(cols_x);
      srow_g = big_x ? '0 : ROW_W'(srow_x);
      col0_g = big_x ? '0 : COL_W'(col0_x);

      total_prod = PROD_W'(rows_g) * PROD_W'(cols_g);
      spos_prod  = PROD_W'(cols_g) * PROD_W'(srow_g) + PROD_W'(col0_g);
   end

   // geometry registers, refreshed every cycle
   always_ff @(posedge clock) begin
      rows_ff  <= rows_g;
      cols_ff  <= cols_g;
      srow_ff  <= srow_g;
      col0_ff  <= col0_g;
      big_ff   <= big_x;
      total_ff <= TOTAL_W'(total_prod);
      spos_ff  <= TOTAL_W'(spos_prod);
   end

   // decode state
   logic [TOTAL_W-1:0] rc_ff, rc_in, pos_ff, pos_in;
   logic               cp_ff, cp_in;
   logic [ROW_W-1:0]   row_ff, row_in;

   logic [TOTAL_W-1:0] rc_cur, pos_cur, n, room, step, pos_step, pos_dn;
   logic               cp_cur, is_digit, n_fit, row_hit, live, run_ok;
   logic [ROW_W-1:0]   row_cur, row_dn;
   logic [7:0]         digit_val;
   logic [MUL_W-1:0]   rc_ext, rc_x10;
   logic [TOTAL_W:0]   row_sum;
   logic [PROD_W-1:0]  line_prod;
   logic [31:0]        start_wide, len_wide;

   always_comb begin
      // restart or pick up the kept state, saturated to the grid in use
      if (first_char) begin
         rc_cur  = '0;
         cp_cur  = 1'b0;
         row_cur = srow_ff;
         pos_cur = spos_ff;
      end else begin
         rc_cur  = rc_ff;
         cp_cur  = cp_ff;
         row_cur = (row_ff > rows_ff) ? rows_ff : row_ff;
         pos_cur = (pos_ff > total_ff) ? total_ff : pos_ff;
      end

      // digit accumulation
      is_digit  = (code_char >= CHAR_ZERO) && (code_char <= CHAR_NINE);
      digit_val = code_char - CHAR_ZERO;
      rc_ext    = MUL_W'(rc_cur);
      rc_x10    = (rc_ext << 3) + (rc_ext << 1) + MUL_W'(digit_val[3:0]);

      // repeat count used up by a non-digit
      if (cp_cur) begin
         n = (rc_cur > total_ff) ? total_ff : rc_cur;
      end else begin
         n = TOTAL_W'(1);
      end

      // horizontal run, cut at the grid end
      room     = total_ff - pos_cur;
      n_fit    = n > room;
      step     = n_fit ? room : n;
      pos_step = pos_cur + step;

      // row advance back to the left column
      row_sum   = (TOTAL_W + 1)'(row_cur) + (TOTAL_W + 1)'(n);
      row_hit   = row_sum >= (TOTAL_W + 1)'(rows_ff);
      row_dn    = row_hit ? rows_ff : ROW_W'(row_sum);
      line_prod = PROD_W'(cols_ff) * PROD_W'(row_dn) + PROD_W'(col0_ff);
      pos_dn    = row_hit ? total_ff : TOTAL_W'(line_prod);

      // next state
      rc_in  = rc_cur;
      cp_in  = cp_cur;
      row_in = first_char ? srow_ff : row_ff;
      pos_in = first_char ? spos_ff : pos_ff;
      live   = 1'b0;
      if (is_digit) begin
         rc_in = ((MUL_W'(total_ff)) < rc_x10) ? total_ff : TOTAL_W'(rc_x10);
         cp_in = 1'b1;
      end else begin
         rc_in = '0;
         cp_in = 1'b0;
         if (!big_ff) begin
            row_in = row_cur;
            pos_in = pos_cur;
            unique case (code_char)
               CHAR_RUN_LIVE: begin
                  pos_in = pos_step;
                  live   = 1'b1;
               end
               CHAR_RUN_DEAD: begin
                  pos_in = pos_step;
               end
               CHAR_ROW_END: begin
                  row_in = row_dn;
                  pos_in = pos_dn;
               end
               default: begin
               end
            endcase
         end
      end

      // result word
      run_ok     = live && (step != '0);
      start_wide = run_ok ? 32'(pos_cur) : 32'd0;
      len_wide   = run_ok ? 32'(step) : 32'd0;
      result.run_valid  = run_ok;
      result.run_start  = start_wide[START_W-1:0];
      result.run_length = len_wide[LEN_W-1:0];
      result.too_large  = big_ff;
      result.clipped    = live && n_fit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_ff  <= '0;
         cp_ff  <= 1'b0;
         row_ff <= '0;
         pos_ff <= '0;
      end else if (item_accept) begin
         rc_ff  <= rc_in;
         cp_ff  <= cp_in;
         row_ff <= row_in;
         pos_ff <= pos_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/rlepd_out_buf.sv
// two-entry result buffer: output register plus skid register
// depends on rlepd_pkg
`default_nettype none

module rlepd_out_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  rlepd_pkg::rsp_word_type in_word,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rlepd_pkg::rsp_word_type out_word
);
   import rlepd_pkg::*;

   rsp_word_type main_ff, skid_ff;
   logic         main_valid_ff, skid_valid_ff;
   logic         in_fire, out_fire;

   assign in_ready  = !skid_valid_ff;
   assign in_fire   = in_valid && in_ready;
   assign out_fire  = main_valid_ff && out_ready;
   assign out_valid = main_valid_ff;
   assign out_word  = main_ff;

   // control: occupancy of the two entries
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!main_valid_ff || out_fire) begin
         main_valid_ff <= skid_valid_ff || in_fire;
         skid_valid_ff <= 1'b0;
      end else if (in_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // payload: skid drains first, new word lands where there is room
   always_ff @(posedge clock) begin
      if (!main_valid_ff || out_fire) begin
         main_ff <= skid_valid_ff ? skid_ff : in_word;
      end else if (in_fire) begin
         skid_ff <= in_word;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/rlepd_checker.sv
// port-level checks of the run-length pattern decoder, bound to the top level
// depends on rlepd_pkg and rle_pattern_run_decoder_top_macros.svh
`default_nettype none

`include "rle_pattern_run_decoder_top_macros.svh"

module rlepd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            run_valid,
   input logic [rlepd_pkg::START_W-1:0]   run_start,
   input logic [rlepd_pkg::LEN_W-1:0]     run_length,
   input logic                            too_large,
   input logic                            clipped
);
   import rlepd_pkg::*;

   // a stalled result word holds
   `RLEPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(run_valid) && $stable(run_start) && $stable(run_length) && $stable(too_large) && $stable(clipped), "result word changed while stalled")

   // after every accepted word, a result word is valid in the next cycle
   `RLEPD_ASSERT_NEXT(a_accept_to_rsp, clock, reset, req_valid && req_ready, rsp_valid, "accepted word gave no result")

   // a live run always covers cells
   `RLEPD_ASSERT_IMPL(a_run_nonempty, clock, reset, rsp_valid && run_valid, run_length != '0, "live run with zero length")

   // no run fields without a live run
   `RLEPD_ASSERT_IMPL(a_idle_fields, clock, reset, rsp_valid && !run_valid, run_start == '0 && run_length == '0, "run fields set without a live run")

   // an oversized pattern places nothing
   `RLEPD_ASSERT_IMPL(a_too_large_quiet, clock, reset, rsp_valid && too_large, !run_valid && !clipped, "oversized pattern placed cells")

endmodule

bind rle_pattern_run_decoder_top rlepd_checker u_rlepd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .run_valid  (rsp_bus.run_valid),
   .run_start  (rsp_bus.run_start),
   .run_length (rsp_bus.run_length),
   .too_large  (rsp_bus.too_large),
   .clipped    (rsp_bus.clipped)
);

`default_nettype wire
